/* src/fraction_arith_reduce_assert.svh */
// Assertion macros shared by the fraction arithmetic block.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef FRACTION_ARITH_REDUCE_ASSERT_SVH
`define FRACTION_ARITH_REDUCE_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define FRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold outside reset.
`define FRA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/fra_pkg.sv */
// Package for the fraction arithmetic block: operation codes, multiplier
// operand selection, and the command and status structs between control and datapath.
package fra_pkg;

  localparam int OPERAND_BITS_DEF = 16;
  localparam int RES_BITS         = 33;
  localparam int MODE_BITS        = 3;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_MUL   = 3'd2,
    MODE_DIV   = 3'd3,
    MODE_HMEAN = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    MUL_AD = 2'd0,
    MUL_CB = 2'd1,
    MUL_AC = 2'd2,
    MUL_BD = 2'd3
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     form;
    logic     load_mag;
    logic     twos_step;
    logic     save_nd;
    logic     odd_step;
    logic     div_init;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic num_zero;
    logic x_zero;
    logic y_zero;
    logic x_even;
    logic y_even;
  } sts_t;

endpackage

/* src/fraction_arith_reduce.sv */
// Fraction arithmetic with GCD reduction, one request at a time (W = 2*OPERAND_BITS+1).
// Four products on the shared multiplier, the raw fraction and its magnitudes, then the
// binary GCD (length set by the operand magnitudes), W division steps, the result load.
// A zero numerator skips GCD and division: the result loads after the magnitude step.
// A new request is taken the cycle after the result is loaded, even while it waits.
// rst_ni clears the controller and the result valid asynchronously; data is not reset.
module fraction_arith_reduce #(
  parameter int OPERAND_BITS = fra_pkg::OPERAND_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [fra_pkg::MODE_BITS-1:0]       mode_i,
  input  logic signed [OPERAND_BITS-1:0]      num_a_i,
  input  logic signed [OPERAND_BITS-1:0]      den_b_i,
  input  logic signed [OPERAND_BITS-1:0]      num_c_i,
  input  logic signed [OPERAND_BITS-1:0]      den_d_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fra_pkg::RES_BITS-1:0] res_num_o,
  output logic signed [fra_pkg::RES_BITS-1:0] res_den_o,
  output logic                                den_zero_o
);

  fra_pkg::cmd_t cmd;
  fra_pkg::sts_t sts;

  fra_ctrl #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fra_dpath #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_dpath (
    .clk_i     (clk_i),
    .mode_i    (mode_i),
    .num_a_i   (num_a_i),
    .den_b_i   (den_b_i),
    .num_c_i   (num_c_i),
    .den_d_i   (den_d_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .den_zero_o(den_zero_o)
  );

endmodule

/* src/fra_dpath.sv */
// Datapath of the fraction arithmetic block: shared multiplier, raw fraction,
// binary GCD registers, two restoring dividers and the result register. Uses fra_pkg.
module fra_dpath #(
  parameter int OPERAND_BITS = fra_pkg::OPERAND_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic [fra_pkg::MODE_BITS-1:0]     mode_i,
  input  logic signed [OPERAND_BITS-1:0]    num_a_i,
  input  logic signed [OPERAND_BITS-1:0]    den_b_i,
  input  logic signed [OPERAND_BITS-1:0]    num_c_i,
  input  logic signed [OPERAND_BITS-1:0]    den_d_i,
  input  fra_pkg::cmd_t                     cmd_i,
  output fra_pkg::sts_t                     sts_o,
  output logic signed [fra_pkg::RES_BITS-1:0] res_num_o,
  output logic signed [fra_pkg::RES_BITS-1:0] res_den_o,
  output logic                              den_zero_o
);

  localparam int W       = 2 * OPERAND_BITS + 1;
  localparam int PW      = 2 * OPERAND_BITS;
  localparam int ResBits = fra_pkg::RES_BITS;

  logic [fra_pkg::MODE_BITS-1:0] mode_q;
  logic signed [OPERAND_BITS-1:0] a_q, b_q, c_q, d_q;
  logic signed [PW-1:0] pad_q, pcb_q, pac_q, pbd_q;
  logic signed [OPERAND_BITS-1:0] mul_x, mul_y;
  logic signed [PW-1:0] prod;
  logic signed [W-1:0] num_d, den_d, num_q, den_q;
  logic signed [W-1:0] ad_w, cb_w, ac_w, bd_w;
  logic num_neg_q, den_neg_q;
  logic [W-1:0] x_q, y_q, nm_q, dm_q, g_q;
  logic [W-1:0] qn_q, qd_q, rn_q, rd_q;
  logic [W:0] tn, td, sn, sd;
  logic ge_n, ge_d;
  logic signed [W-1:0] red_num, red_den;
  logic signed [ResBits-1:0] res_num_q, res_den_q;
  logic den_zero_q;

  always_comb begin
    case (cmd_i.mul_sel)
      fra_pkg::MUL_AD: begin mul_x = a_q; mul_y = d_q; end
      fra_pkg::MUL_CB: begin mul_x = c_q; mul_y = b_q; end
      fra_pkg::MUL_AC: begin mul_x = a_q; mul_y = c_q; end
      default:         begin mul_x = b_q; mul_y = d_q; end
    endcase
    prod = mul_x * mul_y;
  end

  assign ad_w = W'(pad_q);
  assign cb_w = W'(pcb_q);
  assign ac_w = W'(pac_q);
  assign bd_w = W'(pbd_q);

  always_comb begin
    case (mode_q)
      fra_pkg::MODE_ADD:   begin num_d = ad_w + cb_w; den_d = bd_w;        end
      fra_pkg::MODE_SUB:   begin num_d = ad_w - cb_w; den_d = bd_w;        end
      fra_pkg::MODE_MUL:   begin num_d = ac_w;        den_d = bd_w;        end
      fra_pkg::MODE_DIV:   begin num_d = ad_w;        den_d = cb_w;        end
      fra_pkg::MODE_HMEAN: begin num_d = ac_w <<< 1;  den_d = ad_w + cb_w; end
      default:             begin num_d = '0;          den_d = '0;          end
    endcase
  end

  // One restoring step for each quotient; both share the divisor.
  always_comb begin
    tn   = {rn_q, qn_q[W-1]};
    td   = {rd_q, qd_q[W-1]};
    sn   = tn - {1'b0, g_q};
    sd   = td - {1'b0, g_q};
    ge_n = tn >= {1'b0, g_q};
    ge_d = td >= {1'b0, g_q};
  end

  assign red_num = num_neg_q ? -$signed(qn_q) : $signed(qn_q);
  assign red_den = den_neg_q ? -$signed(qd_q) : $signed(qd_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_i;
      a_q    <= num_a_i;
      b_q    <= den_b_i;
      c_q    <= num_c_i;
      d_q    <= den_d_i;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        fra_pkg::MUL_AD: pad_q <= prod;
        fra_pkg::MUL_CB: pcb_q <= prod;
        fra_pkg::MUL_AC: pac_q <= prod;
        default:         pbd_q <= prod;
      endcase
    end
    if (cmd_i.form) begin
      num_q <= num_d;
      den_q <= den_d;
    end
    if (cmd_i.load_mag) begin
      num_neg_q <= num_q[W-1];
      den_neg_q <= den_q[W-1];
      x_q       <= num_q[W-1] ? W'(-num_q) : W'(num_q);
      y_q       <= den_q[W-1] ? W'(-den_q) : W'(den_q);
    end
    if (cmd_i.twos_step) begin
      x_q <= x_q >> 1;
      y_q <= y_q >> 1;
    end
    if (cmd_i.save_nd) begin
      nm_q <= x_q;
      dm_q <= y_q;
    end
    // Binary GCD on the odd parts: halve an even side, else subtract the smaller.
    if (cmd_i.odd_step) begin
      if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q > y_q) begin
        x_q <= y_q;
        y_q <= x_q - y_q;
      end else begin
        y_q <= y_q - x_q;
      end
    end
    if (cmd_i.div_init) begin
      g_q  <= x_q;
      qn_q <= nm_q;
      qd_q <= dm_q;
      rn_q <= '0;
      rd_q <= '0;
    end
    if (cmd_i.div_step) begin
      rn_q <= ge_n ? sn[W-1:0] : tn[W-1:0];
      rd_q <= ge_d ? sd[W-1:0] : td[W-1:0];
      qn_q <= {qn_q[W-2:0], ge_n};
      qd_q <= {qd_q[W-2:0], ge_d};
    end
    if (cmd_i.out_load) begin
      if (num_q == '0) begin
        res_num_q <= ResBits'(num_q);
        res_den_q <= ResBits'(den_q);
      end else begin
        res_num_q <= ResBits'(red_num);
        res_den_q <= ResBits'(red_den);
      end
      den_zero_q <= (den_q == '0);
    end
  end

  assign sts_o.num_zero = (num_q == '0);
  assign sts_o.x_zero   = (x_q == '0);
  assign sts_o.y_zero   = (y_q == '0);
  assign sts_o.x_even   = !x_q[0];
  assign sts_o.y_even   = !y_q[0];

  assign res_num_o  = res_num_q;
  assign res_den_o  = res_den_q;
  assign den_zero_o = den_zero_q;

endmodule

/* src/fra_ctrl.sv */
// Controller of the fraction arithmetic block: sequences multiply, form, GCD,
// division and output phases, and owns both handshakes. Uses fra_pkg and the assert macros.
`include "fraction_arith_reduce_assert.svh"

module fra_ctrl #(
  parameter int OPERAND_BITS = fra_pkg::OPERAND_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fra_pkg::sts_t sts_i,
  output fra_pkg::cmd_t cmd_o
);

  localparam int W     = 2 * OPERAND_BITS + 1;
  localparam int CNT_W = $clog2(W + 1);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL  = 8'b0000_0010,
    ST_FORM = 8'b0000_0100,
    ST_MAG  = 8'b0000_1000,
    ST_TWOS = 8'b0001_0000,
    ST_ODD  = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic in_acc, out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    cmd_o.mul_sel = fra_pkg::mul_sel_e'(cnt_q[1:0]);
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.load_in = 1'b1;
          cnt_d         = '0;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = ST_FORM;
        end
      end
      ST_FORM: begin
        cmd_o.form = 1'b1;
        state_d    = ST_MAG;
      end
      ST_MAG: begin
        // A zero numerator leaves the raw fraction as it stands.
        cmd_o.load_mag = 1'b1;
        state_d        = sts_i.num_zero ? ST_FIN : ST_TWOS;
      end
      ST_TWOS: begin
        if (sts_i.y_zero || !sts_i.x_even || !sts_i.y_even) begin
          cmd_o.save_nd = 1'b1;
          state_d       = ST_ODD;
        end else begin
          cmd_o.twos_step = 1'b1;
        end
      end
      ST_ODD: begin
        if (sts_i.y_zero) begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = ST_DIV;
        end else begin
          cmd_o.odd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(W - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `FRA_ASSERT(a_accept_starts_mul, in_acc |=> (state_q == ST_MUL), "accepted request did not start multiply")
  `FRA_ASSERT_NEVER(a_gcd_x_nonzero, ((state_q == ST_TWOS) || (state_q == ST_ODD)) && sts_i.x_zero, "GCD operand reached zero")
  `FRA_ASSERT(a_valid_from_fin, $rose(out_valid_o) |-> $past(state_q == ST_FIN), "result raised outside the finish phase")

endmodule
